@@ hw/rtl/cse_pkg.sv @@
// cse_pkg: shared types, codes and micro-step tables for the cubic spline evaluator.
// Used by cse_ctrl, cse_datapath and cubic_spline_evaluator; depends on nothing.
package cse_pkg;

	localparam int MAX_KNOTS_DEF = 64;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CNT_W         = 7;
	localparam int NUM_STEPS     = 13;
	localparam int PP_LAST       = 6;
	localparam int DIV_STEPS     = 33;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [5:0]         knot_index;
		logic signed [31:0] knot_x;
		logic signed [31:0] knot_y;
		logic signed [31:0] knot_curv;
		logic signed [31:0] query_x;
	} cse_in_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [31:0] slope;
		logic               out_of_range;
		logic               was_load;
	} cse_out_t;

	// multiply operand pairs
	typedef enum logic [3:0] {
		MOP_AB,
		MOP_ABHA,
		MOP_ABHB,
		MOP_TK0,
		MOP_T2K1,
		MOP_AY0,
		MOP_BY1,
		MOP_HH,
		MOP_3AA,
		MOP_3BB
	} mac_op_t;

	typedef enum logic [2:0] {
		SV_NONE,
		SV_AB,
		SV_TMP,
		SV_TMP2,
		SV_T,
		SV_YS,
		SV_CV
	} save_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_LATCH_IN,
		DP_LAT_FIRST,
		DP_LAT_SEG,
		DP_CALC_HAB,
		DP_CALC_SUMS,
		DP_SAVE,
		DP_PREP1,
		DP_PREP2,
		DP_PREP3,
		DP_DIV_INIT_V,
		DP_DIV_INIT_S,
		DP_DIV_STEP,
		DP_DIV_FIN_V,
		DP_DIV_FIN_S
	} dp_op_t;

	typedef enum logic [1:0] {
		EM_LOAD,
		EM_RANGE,
		EM_FLAT,
		EM_EVAL
	} emit_t;

	typedef struct packed {
		dp_op_t     op;
		save_t      save;
		logic       mac_en;
		logic       mac_clr;
		logic       mac_neg;
		mac_op_t    mac_op;
		logic [2:0] mac_pp;
		logic       tbl_we;
		logic       emit;
		emit_t      kind;
	} cse_cmd_t;

	typedef struct packed {
		logic outside;
		logic pos_lt_q;
		logic h_zero;
	} cse_sts_t;

	typedef struct packed {
		mac_op_t op;
		logic    clr;
		logic    neg;
		save_t   save;
	} step_t;

	// multiply-accumulate program: value terms, then slope terms
	function automatic step_t step_info(input logic [3:0] s);
		step_t r;
		unique case (s)
			4'd0:    r = '{MOP_AB,   1'b1, 1'b0, SV_AB};
			4'd1:    r = '{MOP_ABHA, 1'b1, 1'b0, SV_TMP};
			4'd2:    r = '{MOP_ABHB, 1'b1, 1'b0, SV_TMP2};
			4'd3:    r = '{MOP_TK0,  1'b1, 1'b0, SV_NONE};
			4'd4:    r = '{MOP_T2K1, 1'b0, 1'b0, SV_T};
			4'd5:    r = '{MOP_AY0,  1'b1, 1'b0, SV_NONE};
			4'd6:    r = '{MOP_BY1,  1'b0, 1'b0, SV_YS};
			4'd7:    r = '{MOP_HH,   1'b1, 1'b0, SV_NONE};
			4'd8:    r = '{MOP_3AA,  1'b0, 1'b1, SV_TMP};
			4'd9:    r = '{MOP_3BB,  1'b1, 1'b0, SV_NONE};
			4'd10:   r = '{MOP_HH,   1'b0, 1'b1, SV_TMP2};
			4'd11:   r = '{MOP_TK0,  1'b1, 1'b0, SV_NONE};
			4'd12:   r = '{MOP_T2K1, 1'b0, 1'b0, SV_CV};
			default: r = '{MOP_AB,   1'b0, 1'b0, SV_NONE};
		endcase
		return r;
	endfunction

	// 32-bit limb of the wide operand for each partial product
	function automatic logic [1:0] pp_p_limb(input logic [2:0] pp);
		logic [1:0] r;
		case (pp)
			3'd0, 3'd4: r = 2'd0;
			3'd1, 3'd5: r = 2'd1;
			3'd2, 3'd6: r = 2'd2;
			3'd3:       r = 2'd3;
			default:    r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic pp_q_limb(input logic [2:0] pp);
		return pp >= 3'd4;
	endfunction

endpackage

@@ hw/rtl/cse_datapath.sv @@
// cse_datapath: knot tables, 33x33 multiply-accumulate unit, numerator setup and
// restoring divider for the cubic spline evaluator. Depends on cse_pkg.
module cse_datapath #(
	parameter int MAX_KNOTS = cse_pkg::MAX_KNOTS_DEF,
	parameter int FRAC_BITS = cse_pkg::FRAC_BITS_DEF,
	parameter int IDX_W     = $clog2(MAX_KNOTS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cse_pkg::cse_in_t  in_data,
	input  cse_pkg::cse_cmd_t cmd,
	input  logic [IDX_W-1:0]  addr_a,
	input  logic [IDX_W-1:0]  addr_b,
	output cse_pkg::cse_sts_t sts,
	output cse_pkg::cse_out_t out_data
);
	import cse_pkg::*;

	cse_in_t in_q;

	logic [31:0] pos_mem [MAX_KNOTS];
	logic [31:0] val_mem [MAX_KNOTS];
	logic [31:0] crv_mem [MAX_KNOTS];
	logic signed [31:0] pa_q, pb_q, va_q, vb_q, ca_q, cb_q;

	logic signed [31:0] first_q, x0_q, x1_q, y0_q, y1_q, k0_q, k1_q;
	logic [63:0]  h_q, a_q, b_q, ha_q, hb_q, ab_q, ys_q, d6_q;
	logic [65:0]  a3_q, b3_q;
	logic [127:0] tmp_q, tmp2_q, t_q, cv_q, acc_q;
	logic [127:0] yt_q, dy6_q, my_q, mt_q, vmag_q, smag_q;
	logic         ny_q, nt_q, vneg_q, sneg_q;

	logic [127:0] dv_d_q, dv_r_q;
	logic [32:0]  dv_lo_q, dv_qt_q;
	logic         dv_sat_q, dv_neg_q;
	logic signed [31:0] res_v_q, res_s_q;

	logic signed [65:0] prod_s1;
	logic [1:0]         shift_s1;
	logic               neg_s1, vld_s1;

	cse_out_t out_q;

	logic              wr_ok;
	logic [IDX_W-1:0]  waddr;
	logic [127:0]      p_op;
	logic [63:0]       q_op;
	logic              q_sgn;
	logic [1:0]        pi;
	logic              qj;
	logic [31:0]       p_limb;
	logic [32:0]       q_limb;
	logic [127:0]      pp_wide, pp_shift;
	logic signed [32:0] dh, da, db, dy;
	logic [127:0]      u_t, d_v, d_s, div_mag, div_d, r2;
	logic              div_neg, r_ge;

	function automatic logic [127:0] times6_sh(input logic [127:0] v);
		logic [127:0] s;
		s = (v << 2) + (v << 1);
		return s << (2 * FRAC_BITS);
	endfunction

	function automatic logic [31:0] div_result(input logic sat, input logic neg,
	                                           input logic [32:0] qt,
	                                           input logic [127:0] rem);
		logic [33:0] qn;
		logic [31:0] r;
		qn = {1'b0, qt} + {33'b0, (rem != '0)};
		if (neg) begin
			if (sat || qn > 34'h0_8000_0000) r = 32'h8000_0000;
			else r = 32'(34'd0 - qn);
		end else begin
			if (sat || qt > 33'h0_7FFF_FFFF) r = 32'h7FFF_FFFF;
			else r = qt[31:0];
		end
		return r;
	endfunction

	assign wr_ok = 32'(in_q.knot_index) < 32'(MAX_KNOTS);
	assign waddr = IDX_W'(in_q.knot_index);

	// knot tables, one write port and two registered read ports each
	always_ff @(posedge clk) begin
		if (cmd.tbl_we && wr_ok) begin
			pos_mem[waddr] <= in_q.knot_x;
			val_mem[waddr] <= in_q.knot_y;
			crv_mem[waddr] <= in_q.knot_curv;
		end
		pa_q <= pos_mem[addr_a];
		pb_q <= pos_mem[addr_b];
		va_q <= val_mem[addr_a];
		vb_q <= val_mem[addr_b];
		ca_q <= crv_mem[addr_a];
		cb_q <= crv_mem[addr_b];
	end

	assign sts.outside  = (in_q.query_x < first_q) || (in_q.query_x > pa_q);
	assign sts.pos_lt_q = pa_q < in_q.query_x;
	assign sts.h_zero   = x0_q == x1_q;

	assign dh = {x1_q[31], x1_q} - {x0_q[31], x0_q};
	assign da = {x1_q[31], x1_q} - {in_q.query_x[31], in_q.query_x};
	assign db = {in_q.query_x[31], in_q.query_x} - {x0_q[31], x0_q};
	assign dy = {y1_q[31], y1_q} - {y0_q[31], y0_q};

	// operand selection for the multiply-accumulate unit
	always_comb begin
		p_op  = '0;
		q_op  = '0;
		q_sgn = 1'b0;
		case (cmd.mac_op)
			MOP_AB: begin
				p_op = {64'b0, a_q};
				q_op = b_q;
			end
			MOP_ABHA: begin
				p_op = {64'b0, ab_q};
				q_op = ha_q;
			end
			MOP_ABHB: begin
				p_op = {64'b0, ab_q};
				q_op = hb_q;
			end
			MOP_TK0: begin
				p_op  = tmp_q;
				q_op  = {{32{k0_q[31]}}, k0_q};
				q_sgn = 1'b1;
			end
			MOP_T2K1: begin
				p_op  = tmp2_q;
				q_op  = {{32{k1_q[31]}}, k1_q};
				q_sgn = 1'b1;
			end
			MOP_AY0: begin
				p_op = {64'b0, a_q};
				q_op = {{32{y0_q[31]}}, y0_q};
			end
			MOP_BY1: begin
				p_op = {64'b0, b_q};
				q_op = {{32{y1_q[31]}}, y1_q};
			end
			MOP_HH: begin
				p_op = {64'b0, h_q};
				q_op = h_q;
			end
			MOP_3AA: begin
				p_op = {62'b0, a3_q};
				q_op = a_q;
			end
			MOP_3BB: begin
				p_op = {62'b0, b3_q};
				q_op = b_q;
			end
			default: begin
				p_op = '0;
				q_op = '0;
			end
		endcase
	end

	assign pi     = pp_p_limb(cmd.mac_pp);
	assign qj     = pp_q_limb(cmd.mac_pp);
	assign p_limb = p_op[{pi, 5'b0} +: 32];
	assign q_limb = qj ? {q_sgn & q_op[63], q_op[63:32]} : {1'b0, q_op[31:0]};

	always_ff @(posedge clk) begin
		prod_s1  <= $signed({1'b0, p_limb}) * $signed(q_limb);
		shift_s1 <= pi + {1'b0, qj};
		neg_s1   <= cmd.mac_neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.mac_en;
		end
	end

	assign pp_wide  = {{62{prod_s1[65]}}, prod_s1};
	assign pp_shift = pp_wide << {shift_s1, 5'b0};

	always_ff @(posedge clk) begin
		if (cmd.mac_en && cmd.mac_clr) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= neg_s1 ? acc_q - pp_shift : acc_q + pp_shift;
		end
	end

	// divisors: 6h scaled by 2^2F for the value, 2^F for the slope
	assign d_v = {64'b0, d6_q} << (2 * FRAC_BITS);
	assign d_s = {64'b0, d6_q} << FRAC_BITS;
	assign u_t = 128'd0 - t_q;

	always_comb begin
		div_mag = vmag_q;
		div_neg = vneg_q;
		div_d   = d_v;
		if (cmd.op == DP_DIV_INIT_S) begin
			div_mag = smag_q;
			div_neg = sneg_q;
			div_d   = d_s;
		end
	end

	assign r2   = {dv_r_q[126:0], dv_lo_q[32]};
	assign r_ge = r2 >= dv_d_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LATCH_IN: in_q <= in_data;
			DP_LAT_FIRST: first_q <= pa_q;
			DP_LAT_SEG: begin
				x1_q <= pb_q;
				x0_q <= pa_q;
				y0_q <= va_q;
				y1_q <= vb_q;
				k0_q <= ca_q;
				k1_q <= cb_q;
			end
			DP_CALC_HAB: begin
				h_q <= {{31{dh[32]}}, dh};
				a_q <= {{31{da[32]}}, da};
				b_q <= {{31{db[32]}}, db};
			end
			DP_CALC_SUMS: begin
				ha_q <= h_q + a_q;
				hb_q <= h_q + b_q;
				a3_q <= {2'b0, a_q} + {1'b0, a_q, 1'b0};
				b3_q <= {2'b0, b_q} + {1'b0, b_q, 1'b0};
				d6_q <= (h_q << 2) + (h_q << 1);
			end
			DP_SAVE: begin
				case (cmd.save)
					SV_AB:   ab_q   <= acc_q[63:0];
					SV_TMP:  tmp_q  <= acc_q;
					SV_TMP2: tmp2_q <= acc_q;
					SV_T:    t_q    <= acc_q;
					SV_YS:   ys_q   <= acc_q[63:0];
					SV_CV:   cv_q   <= acc_q;
					default: ;
				endcase
			end
			DP_PREP1: begin
				yt_q  <= times6_sh({{64{ys_q[63]}}, ys_q});
				dy6_q <= times6_sh({{95{dy[32]}}, dy});
			end
			DP_PREP2: begin
				ny_q <= yt_q[127];
				my_q <= yt_q[127] ? 128'd0 - yt_q : yt_q;
				nt_q <= u_t[127];
				mt_q <= u_t[127] ? t_q : u_t;
				cv_q <= cv_q + dy6_q;
			end
			DP_PREP3: begin
				// sign-magnitude sum of the two value terms
				if (ny_q == nt_q) begin
					vneg_q <= ny_q;
					vmag_q <= my_q + mt_q;
				end else if (my_q >= mt_q) begin
					vneg_q <= ny_q;
					vmag_q <= my_q - mt_q;
				end else begin
					vneg_q <= nt_q;
					vmag_q <= mt_q - my_q;
				end
				sneg_q <= cv_q[127];
				smag_q <= cv_q[127] ? 128'd0 - cv_q : cv_q;
			end
			DP_DIV_INIT_V, DP_DIV_INIT_S: begin
				// quotient of 2^33 or more saturates, otherwise 33 steps suffice
				dv_d_q   <= div_d;
				dv_sat_q <= {33'b0, div_mag} >= {div_d, 33'b0};
				dv_r_q   <= div_mag >> 33;
				dv_lo_q  <= div_mag[32:0];
				dv_neg_q <= div_neg;
				dv_qt_q  <= '0;
			end
			DP_DIV_STEP: begin
				dv_r_q  <= r_ge ? r2 - dv_d_q : r2;
				dv_qt_q <= {dv_qt_q[31:0], r_ge};
				dv_lo_q <= dv_lo_q << 1;
			end
			DP_DIV_FIN_V: res_v_q <= div_result(dv_sat_q, dv_neg_q, dv_qt_q, dv_r_q);
			DP_DIV_FIN_S: res_s_q <= div_result(dv_sat_q, dv_neg_q, dv_qt_q, dv_r_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.kind)
				EM_LOAD:  out_q <= '{32'sd0, 32'sd0, 1'b0, 1'b1};
				EM_RANGE: out_q <= '{32'sd0, 32'sd0, 1'b1, 1'b0};
				EM_FLAT:  out_q <= '{y0_q, 32'sd0, 1'b0, 1'b0};
				default:  out_q <= '{res_v_q, res_s_q, 1'b0, 1'b0};
			endcase
		end
	end

	assign out_data = out_q;

endmodule

@@ hw/rtl/cse_ctrl.sv @@
// cse_ctrl: sequencer for the cubic spline evaluator: handshakes, knot count
// register, segment search, multiply program and divider steps. Depends on cse_pkg.
module cse_ctrl #(
	parameter int MAX_KNOTS = cse_pkg::MAX_KNOTS_DEF,
	parameter int IDX_W     = $clog2(MAX_KNOTS)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      req_type,
	output logic                      out_valid,
	input  logic                      out_stall,
	input  logic                      cfg_we,
	input  logic [cse_pkg::CNT_W-1:0] cfg_data,
	input  cse_pkg::cse_sts_t         sts,
	output cse_pkg::cse_cmd_t         cmd,
	output logic [IDX_W-1:0]          addr_a,
	output logic [IDX_W-1:0]          addr_b
);
	import cse_pkg::*;

	typedef enum logic [19:0] {
		ST_IDLE  = 20'h00001,
		ST_LOAD  = 20'h00002,
		ST_RD0   = 20'h00004,
		ST_RDL   = 20'h00008,
		ST_CHK   = 20'h00010,
		ST_SRCH  = 20'h00020,
		ST_FETCH = 20'h00040,
		ST_LATCH = 20'h00080,
		ST_HCHK  = 20'h00100,
		ST_SUMS  = 20'h00200,
		ST_MAC   = 20'h00400,
		ST_DRAIN = 20'h00800,
		ST_SAVE  = 20'h01000,
		ST_PREP1 = 20'h02000,
		ST_PREP2 = 20'h04000,
		ST_PREP3 = 20'h08000,
		ST_DINIT = 20'h10000,
		ST_DSTEP = 20'h20000,
		ST_DFIN  = 20'h40000,
		ST_EMIT  = 20'h80000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] knot_count_q;
	logic [IDX_W-1:0] cur_q, cur_d, nk_last;
	logic [3:0]       step_q, step_d;
	logic [2:0]       pp_q, pp_d;
	logic [5:0]       dcnt_q, dcnt_d;
	logic             slope_q, slope_d;
	emit_t            kind_q, kind_d;
	logic             out_valid_q;
	step_t            si;
	logic             accept;

	always_comb begin
		if (knot_count_q < CNT_W'(2)) nk_last = IDX_W'(1);
		else if (32'(knot_count_q) > 32'(MAX_KNOTS)) nk_last = IDX_W'(MAX_KNOTS - 1);
		else nk_last = IDX_W'(knot_count_q - CNT_W'(1));
	end

	assign in_stall  = state_q != ST_IDLE;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign si        = step_info(step_q);

	always_comb begin
		state_d = state_q;
		cur_d   = cur_q;
		step_d  = step_q;
		pp_d    = pp_q;
		dcnt_d  = dcnt_q;
		slope_d = slope_q;
		kind_d  = kind_q;
		cmd     = '{DP_NONE, SV_NONE, 1'b0, 1'b0, 1'b0, MOP_AB, 3'd0, 1'b0, 1'b0, kind_q};
		addr_a  = '0;
		addr_b  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.op  = DP_LATCH_IN;
					state_d = (req_type == REQ_LOAD) ? ST_LOAD : ST_RD0;
				end
			end
			ST_LOAD: begin
				cmd.tbl_we = 1'b1;
				kind_d     = EM_LOAD;
				state_d    = ST_EMIT;
			end
			ST_RD0: begin
				state_d = ST_RDL;
			end
			ST_RDL: begin
				addr_a  = nk_last;
				cmd.op  = DP_LAT_FIRST;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (sts.outside) begin
					kind_d  = EM_RANGE;
					state_d = ST_EMIT;
				end else begin
					addr_a  = IDX_W'(1);
					cur_d   = IDX_W'(1);
					state_d = ST_SRCH;
				end
			end
			ST_SRCH: begin
				// linear search, one knot per cycle behind the read port
				addr_a = cur_q + IDX_W'(1);
				if (cur_q < nk_last && sts.pos_lt_q) begin
					cur_d = cur_q + IDX_W'(1);
				end else begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				addr_a  = cur_q - IDX_W'(1);
				addr_b  = cur_q;
				state_d = ST_LATCH;
			end
			ST_LATCH: begin
				cmd.op  = DP_LAT_SEG;
				state_d = ST_HCHK;
			end
			ST_HCHK: begin
				cmd.op = DP_CALC_HAB;
				if (sts.h_zero) begin
					kind_d  = EM_FLAT;
					state_d = ST_EMIT;
				end else begin
					state_d = ST_SUMS;
				end
			end
			ST_SUMS: begin
				cmd.op  = DP_CALC_SUMS;
				step_d  = '0;
				pp_d    = '0;
				state_d = ST_MAC;
			end
			ST_MAC: begin
				cmd.mac_en  = 1'b1;
				cmd.mac_op  = si.op;
				cmd.mac_neg = si.neg;
				cmd.mac_clr = si.clr && (pp_q == 3'd0);
				cmd.mac_pp  = pp_q;
				pp_d        = pp_q + 3'd1;
				if (pp_q == 3'(PP_LAST)) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_SAVE;
			end
			ST_SAVE: begin
				cmd.op   = DP_SAVE;
				cmd.save = si.save;
				pp_d     = '0;
				if (step_q == 4'(NUM_STEPS - 1)) begin
					state_d = ST_PREP1;
				end else begin
					step_d  = step_q + 4'd1;
					state_d = ST_MAC;
				end
			end
			ST_PREP1: begin
				cmd.op  = DP_PREP1;
				state_d = ST_PREP2;
			end
			ST_PREP2: begin
				cmd.op  = DP_PREP2;
				state_d = ST_PREP3;
			end
			ST_PREP3: begin
				cmd.op  = DP_PREP3;
				slope_d = 1'b0;
				state_d = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.op  = slope_q ? DP_DIV_INIT_S : DP_DIV_INIT_V;
				dcnt_d  = '0;
				state_d = ST_DSTEP;
			end
			ST_DSTEP: begin
				cmd.op = DP_DIV_STEP;
				dcnt_d = dcnt_q + 6'd1;
				if (dcnt_q == 6'(DIV_STEPS - 1)) state_d = ST_DFIN;
			end
			ST_DFIN: begin
				cmd.op = slope_q ? DP_DIV_FIN_S : DP_DIV_FIN_V;
				if (slope_q) begin
					kind_d  = EM_EVAL;
					state_d = ST_EMIT;
				end else begin
					slope_d = 1'b1;
					state_d = ST_DINIT;
				end
			end
			ST_EMIT: begin
				cmd.kind = kind_q;
				if (!out_valid_q || !out_stall) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			knot_count_q <= CNT_W'(2);
			cur_q        <= IDX_W'(1);
			step_q       <= '0;
			pp_q         <= '0;
			dcnt_q       <= '0;
			slope_q      <= 1'b0;
			kind_q       <= EM_LOAD;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cur_q   <= cur_d;
			step_q  <= step_d;
			pp_q    <= pp_d;
			dcnt_q  <= dcnt_d;
			slope_q <= slope_d;
			kind_q  <= kind_d;
			if (cfg_we) knot_count_q <= cfg_data;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

@@ hw/rtl/cubic_spline_evaluator.sv @@
// cubic_spline_evaluator: top level, joins cse_ctrl and cse_datapath.
// Depends on cse_pkg, cse_ctrl and cse_datapath.
//
// Usage: the input channel carries one beat per item (in_valid/in_stall, in_data).
// A load beat (req_type 0) writes one knot entry (position, value, curvature) and
// returns an acknowledge beat with was_load set. An evaluate beat (req_type 1)
// returns the spline value and slope at query_x, or zeros with out_of_range set.
// knot_count is written through cfg_we/cfg_data; the user must do so only while the
// block is idle, which the block itself does not enforce. An evaluate runs the
// linear knot search, the segment differences, the 13-step multiply program on the
// single 33x33 multiplier, numerator setup, the two 33-step divisions and the emit;
// a query outside the knots returns from the range check, with no search.
// One item is in work at a time; in_stall is low only when idle.
// The output beat sits in a register: the next item is taken while it waits, and
// a finished result waits while out_stall is high. Reset clears the control state
// and sets knot_count to 2; knot tables hold no defined data until loaded.
module cubic_spline_evaluator #(
	parameter int MAX_KNOTS = cse_pkg::MAX_KNOTS_DEF,
	parameter int FRAC_BITS = cse_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  cse_pkg::cse_in_t          in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output cse_pkg::cse_out_t         out_data,
	input  logic                      cfg_we,
	input  logic [cse_pkg::CNT_W-1:0] cfg_data
);
	import cse_pkg::*;

	localparam int IDX_W = $clog2(MAX_KNOTS);

	cse_cmd_t         cmd;
	cse_sts_t         sts;
	logic [IDX_W-1:0] addr_a, addr_b;

	cse_ctrl #(
		.MAX_KNOTS(MAX_KNOTS),
		.IDX_W    (IDX_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (in_data.req_type),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.sts      (sts),
		.cmd      (cmd),
		.addr_a   (addr_a),
		.addr_b   (addr_b)
	);

	cse_datapath #(
		.MAX_KNOTS(MAX_KNOTS),
		.FRAC_BITS(FRAC_BITS),
		.IDX_W    (IDX_W)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_data (in_data),
		.cmd     (cmd),
		.addr_a  (addr_a),
		.addr_b  (addr_b),
		.sts     (sts),
		.out_data(out_data)
	);

endmodule
